/* hdl/hcbp_pkg.sv */
package hcbp_pkg;

  // Code table geometry and limits.
  localparam int MAX_CODE_LEN  = 32;
  localparam int ALPHABET_SIZE = 256;
  localparam int LEN_CAP       = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int SYM_W         = 8;
  localparam int BITS_W        = 32;
  localparam int LEN_W         = 6;
  localparam int TABLE_DEPTH   = 256;
  localparam int ENTRY_W       = BITS_W + LEN_W;
  localparam int PEND_W        = 7;
  localparam int CNT_W         = 3;
  localparam int STREAM_W      = BITS_W + PEND_W;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  // One code table entry.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [BITS_W-1:0] bits;
  } entry_t;

  // Group of results handed from the packer to the output stage.
  typedef struct packed {
    logic [2:0]        count;
    logic [BITS_W-1:0] bytes;
    logic              byte_valid;
    logic [2:0]        pad;
  } burst_t;

  // Keeps the low len bits of a code.
  function automatic logic [BITS_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [BITS_W:0] m;
    m = ({{BITS_W{1'b0}}, 1'b1} << len) - {{BITS_W{1'b0}}, 1'b1};
    return m[BITS_W-1:0];
  endfunction

endpackage

/* hdl/huffman_code_bit_packer_core.sv */
// Channel  Dir  tdata fields (low bit up)                     tuser      tlast
// s_axis   in   symbol[7:0] code_bits[39:8] code_length[45:40] kind[1:0]  -
// m_axis   out  packed_byte[7:0] pad_bits[10:8]                byte_valid last
//
// An item enters every cycle unless the output stage is still busy with an
// earlier group; results pass the item register and table read, then the
// output stage. An encode yields up to four beats at one per cycle while the
// receiver is ready; the next item with a result waits for the last of them.
// Code table lookup uses a registered memory read beside the item register.
// Synchronous reset clears the accumulator, the output stage and the table
// valid bits at once; no clearing pass is needed.
module huffman_code_bit_packer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // symbol, code_bits, code_length, zero
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // packed_byte, pad_bits, zero
  output logic        m_axis_tuser,   // byte_valid
  output logic        m_axis_tlast    // last
);

  logic [hcbp_pkg::SYM_W-1:0]   symbol;
  logic [hcbp_pkg::BITS_W-1:0]  code_bits;
  logic [hcbp_pkg::LEN_W-1:0]   code_length;
  logic [1:0]                   kind;
  logic                         accept;
  logic                         in_range;
  logic [hcbp_pkg::LEN_W-1:0]   len_sat;
  hcbp_pkg::entry_t             wr_entry;
  logic [hcbp_pkg::ENTRY_W-1:0] rd_data;
  hcbp_pkg::entry_t             entry;
  logic [hcbp_pkg::TABLE_DEPTH-1:0] written;
  logic                         item_valid;
  logic [1:0]                   item_kind;
  logic                         item_hit;
  logic                         item_done;
  logic                         burst_load;
  logic                         emit_free;
  hcbp_pkg::burst_t             burst;

  assign symbol      = s_axis_tdata[7:0];
  assign code_bits   = s_axis_tdata[39:8];
  assign code_length = s_axis_tdata[45:40];
  assign kind        = s_axis_tuser;

  assign s_axis_tready = !item_valid || item_done;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_range      = (32'(symbol) < hcbp_pkg::ALPHABET_SIZE);

  // Load path: saturate the length and mask the code.
  always_comb begin
    len_sat = (32'(code_length) > hcbp_pkg::LEN_CAP)
            ? hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP) : code_length;
    wr_entry.len  = len_sat;
    wr_entry.bits = code_bits & hcbp_pkg::low_mask(len_sat);
  end

  hcbp_ram #(
    .WIDTH (hcbp_pkg::ENTRY_W),
    .DEPTH (hcbp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (accept && kind == hcbp_pkg::KIND_LOAD && in_range),
    .waddr (symbol),
    .wdata (wr_entry),
    .re    (accept && kind == hcbp_pkg::KIND_ENCODE),
    .raddr (symbol),
    .rdata (rd_data)
  );

  // Written marks per table entry; an unwritten entry reads as length zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (accept && kind == hcbp_pkg::KIND_LOAD && in_range) begin
      written[symbol] <= 1'b1;
    end
  end

  // Item register alongside the table read.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_done) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind <= kind;
    end
    if (accept && kind == hcbp_pkg::KIND_ENCODE) begin
      item_hit <= written[symbol] && in_range;
    end
  end

  assign entry = item_hit ? hcbp_pkg::entry_t'(rd_data) : '0;

  hcbp_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_kind  (item_kind),
    .entry      (entry),
    .emit_free  (emit_free),
    .item_done  (item_done),
    .burst_load (burst_load),
    .burst      (burst)
  );

  hcbp_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .burst_load    (burst_load),
    .burst         (burst),
    .emit_free     (emit_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* hdl/hcbp_ram.sv */
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/hcbp_pack.sv */
module hcbp_pack (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic [1:0]          item_kind,
  input  hcbp_pkg::entry_t    entry,
  input  logic                emit_free,
  output logic                item_done,
  output logic                burst_load,
  output hcbp_pkg::burst_t    burst
);

  // Pending bits are held left aligned: the oldest bit sits in the top bit.
  logic [hcbp_pkg::PEND_W-1:0]   pend;
  logic [hcbp_pkg::PEND_W-1:0]   pend_next;
  logic [hcbp_pkg::CNT_W-1:0]    pend_cnt;
  logic [hcbp_pkg::CNT_W-1:0]    pend_cnt_next;
  logic [hcbp_pkg::BITS_W-1:0]   code_left;
  logic [hcbp_pkg::STREAM_W-1:0] stream;
  logic [hcbp_pkg::LEN_W-1:0]    total;
  logic [2:0]                    nbytes;
  logic                          is_encode;
  logic                          is_flush;
  logic                          has_result;

  assign is_encode = item_valid && (item_kind == hcbp_pkg::KIND_ENCODE);
  assign is_flush  = item_valid && (item_kind == hcbp_pkg::KIND_FLUSH);

  // Left align the code and merge it behind the pending bits.
  always_comb begin
    code_left = entry.bits << (hcbp_pkg::LEN_W'(hcbp_pkg::BITS_W) - entry.len);
    stream    = {pend, {hcbp_pkg::BITS_W{1'b0}}}
              | ({code_left, {hcbp_pkg::PEND_W{1'b0}}} >> pend_cnt);
    total     = hcbp_pkg::LEN_W'(pend_cnt) + entry.len;
    nbytes    = total[5:3];
  end

  // Bits left over after the completed bytes.
  always_comb begin
    case (nbytes)
      3'd0:    pend_next = stream[38:32];
      3'd1:    pend_next = stream[30:24];
      3'd2:    pend_next = stream[22:16];
      3'd3:    pend_next = stream[14:8];
      3'd4:    pend_next = stream[6:0];
      default: pend_next = '0;
    endcase
    pend_cnt_next = total[2:0];
  end

  // Build the result group for this item.
  always_comb begin
    burst = '0;
    if (is_flush) begin
      burst.count      = 3'd1;
      burst.bytes      = {pend, 1'b0, 24'd0};
      burst.byte_valid = (pend_cnt != '0);
      burst.pad        = 3'd0 - pend_cnt;
    end else if (is_encode) begin
      burst.count      = nbytes;
      burst.bytes      = stream[38:7];
      burst.byte_valid = 1'b1;
    end
  end

  assign has_result = (burst.count != 3'd0);
  assign item_done  = item_valid && (!has_result || emit_free);
  assign burst_load = item_done && has_result;

  // Bit accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      pend_cnt <= '0;
    end else if (item_done && is_flush) begin
      pend     <= '0;
      pend_cnt <= '0;
    end else if (item_done && is_encode) begin
      pend     <= pend_next;
      pend_cnt <= pend_cnt_next;
    end
  end

`ifndef SYNTH
  // An encode never completes more than four bytes.
  assert property (@(posedge clk) disable iff (rst)
    is_encode |-> (nbytes <= 3'd4))
    else $error("encode completed more than four bytes");

  // A finished flush leaves nothing pending.
  assert property (@(posedge clk) disable iff (rst)
    (item_done && is_flush) |=> (pend_cnt == '0 && pend == '0))
    else $error("accumulator not cleared by flush");

  // Bits below the pending count stay zero.
  assert property (@(posedge clk) disable iff (rst)
    ((pend << pend_cnt) == '0))
    else $error("stray bits in accumulator");
`endif

endmodule

/* hdl/hcbp_emit.sv */
module hcbp_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             burst_load,
  input  hcbp_pkg::burst_t burst,
  output logic             emit_free,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  logic [2:0]                  cnt;
  logic [hcbp_pkg::BITS_W-1:0] bytes;
  logic                        byte_valid;
  logic [2:0]                  pad;
  logic                        take;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign emit_free     = (cnt == 3'd0) || ((cnt == 3'd1) && m_axis_tready);
  assign m_axis_tvalid = (cnt != 3'd0);
  assign m_axis_tdata  = {5'd0, pad, bytes[31:24]};
  assign m_axis_tuser  = byte_valid;
  assign m_axis_tlast  = (cnt == 3'd1);

  // Remaining beat count of the current group.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (burst_load) begin
      cnt <= burst.count;
    end else if (take) begin
      cnt <= cnt - 3'd1;
    end
  end

  // Result bytes, the next one on top.
  always_ff @(posedge clk) begin
    if (burst_load) begin
      bytes      <= burst.bytes;
      byte_valid <= burst.byte_valid;
      pad        <= burst.pad;
    end else if (take) begin
      bytes <= bytes << 8;
    end
  end

`ifndef SYNTH
  // A new group only arrives once the previous one is leaving.
  assert property (@(posedge clk) disable iff (rst)
    burst_load |-> ((cnt == 3'd0) || (cnt == 3'd1 && take)))
    else $error("result group overwritten");

  // The group never holds more than four beats.
  assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4)
    else $error("beat count out of range");
`endif

endmodule

/* test/huffman_code_bit_packer_core_tb.sv */
`timescale 1ns / 1ps

module huffman_code_bit_packer_core_tb;

  // Kind code that the block must ignore.
  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 80;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [hcbp_pkg::SYM_W-1:0]  symbol;
    logic [hcbp_pkg::BITS_W-1:0] code_bits;
    logic [hcbp_pkg::LEN_W-1:0]  code_length;
  } code_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [2:0] pad;
    logic       last;
  } out_beat_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // symbol, code_bits, code_length, zero
  logic [1:0]  s_axis_tuser;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // packed_byte, pad_bits, zero
  logic        m_axis_tuser;   // byte_valid
  logic        m_axis_tlast;   // last

  // Shadow of the code table and the bit accumulator.
  logic [hcbp_pkg::BITS_W-1:0] shadow_code [hcbp_pkg::TABLE_DEPTH];
  logic [hcbp_pkg::LEN_W-1:0]  shadow_len [hcbp_pkg::TABLE_DEPTH];
  logic [hcbp_pkg::PEND_W-1:0] held_bits;
  int                          held_count;

  out_beat_t pending_bytes[$];
  int        error_count;
  int        cycle_count;
  int        hold_request;
  bit        no_idle;

  huffman_code_bit_packer_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h (cycle %0d)", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Updates the shadow state for one accepted item and queues the bytes it
  // should produce.
  task automatic pack_codes(input code_item_t it);
    int          n;
    int          total;
    int          nres;
    int          i;
    int          p;
    logic [63:0] acc;
    logic [63:0] mask;
    logic [63:0] shifted;
    logic [7:0]  part;
    out_beat_t   b;
    case (it.kind)
      hcbp_pkg::KIND_LOAD: begin
        if (int'(it.symbol) < hcbp_pkg::ALPHABET_SIZE) begin
          n = (int'(it.code_length) > hcbp_pkg::LEN_CAP) ? hcbp_pkg::LEN_CAP
                                                          : int'(it.code_length);
          mask = (64'd1 << n) - 64'd1;
          shadow_len[it.symbol] = n[hcbp_pkg::LEN_W-1:0];
          shadow_code[it.symbol] = it.code_bits & mask[hcbp_pkg::BITS_W-1:0];
        end
      end
      hcbp_pkg::KIND_ENCODE: begin
        n = int'(shadow_len[it.symbol]);
        if (int'(it.symbol) < hcbp_pkg::ALPHABET_SIZE && n != 0) begin
          acc = ({57'd0, held_bits} << n) | {32'd0, shadow_code[it.symbol]};
          total = held_count + n;
          nres = total / 8;
          if (nres > 4) nres = 4;
          for (i = 0; i < nres; i++) begin
            total = total - 8;
            shifted = acc >> total;
            b.data = shifted[7:0];
            b.valid = 1'b1;
            b.pad = 3'd0;
            b.last = (i == nres - 1);
            pending_bytes.push_back(b);
          end
          // Whatever remains below a whole byte stays in the accumulator.
          part = (8'd1 << total) - 8'd1;
          held_bits = acc[hcbp_pkg::PEND_W-1:0] & part[hcbp_pkg::PEND_W-1:0];
          held_count = total % 8;
        end
      end
      hcbp_pkg::KIND_FLUSH: begin
        b.last = 1'b1;
        if (held_count == 0) begin
          b.data = 8'd0;
          b.valid = 1'b0;
          b.pad = 3'd0;
        end else begin
          p = 8 - held_count;
          part = {1'b0, held_bits};
          b.data = part << p;
          b.valid = 1'b1;
          b.pad = p[2:0];
        end
        pending_bytes.push_back(b);
        held_bits = '0;
        held_count = 0;
      end
      default: begin
      end
    endcase
  endtask

  // Offers one item after a random gap and predicts it once it is taken.
  task automatic send_item(input code_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata = {2'b00, it.code_length, it.code_bits, it.symbol};
    s_axis_tuser = it.kind;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pack_codes(it);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic code_item_t make_item(input logic [1:0] kind,
                                           input int sym, input logic [31:0] bits,
                                           input int len);
    code_item_t it;
    it.kind = kind;
    it.symbol = sym[hcbp_pkg::SYM_W-1:0];
    it.code_bits = bits;
    it.code_length = len[hcbp_pkg::LEN_W-1:0];
    return it;
  endfunction

  // Random item: mostly encodes of a small set of symbols so that loaded
  // codes are used, with loads, flushes and the odd ignored kind mixed in.
  function automatic code_item_t random_item();
    code_item_t it;
    int         r;
    int         lr;
    r = $urandom_range(0, 99);
    if (r < 18) it.kind = hcbp_pkg::KIND_LOAD;
    else if (r < 85) it.kind = hcbp_pkg::KIND_ENCODE;
    else if (r < 96) it.kind = hcbp_pkg::KIND_FLUSH;
    else it.kind = KIND_IGNORED;
    it.symbol = ($urandom_range(0, 3) == 0)
              ? hcbp_pkg::SYM_W'($urandom_range(0, 255))
              : hcbp_pkg::SYM_W'($urandom_range(0, 15));
    it.code_bits = $urandom;
    lr = $urandom_range(0, 99);
    if (lr < 5) it.code_length = 6'd0;
    else if (lr < 75) it.code_length = hcbp_pkg::LEN_W'($urandom_range(1, 12));
    else if (lr < 92) it.code_length = hcbp_pkg::LEN_W'($urandom_range(13, 32));
    else it.code_length = hcbp_pkg::LEN_W'($urandom_range(33, 63));
    return it;
  endfunction

  task automatic wait_drain();
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Extremes of the fields and each special case once.
  task automatic test_directed();
    send_item(make_item(hcbp_pkg::KIND_LOAD, 0, 32'hFFFF_FFFF, 0));
    send_item(make_item(hcbp_pkg::KIND_LOAD, 255, 32'hFFFF_FFFF, 32));
    send_item(make_item(hcbp_pkg::KIND_LOAD, 1, 32'hFFFF_FFFF, 1));
    send_item(make_item(hcbp_pkg::KIND_LOAD, 2, 32'hFFFF_FF55, 7));
    send_item(make_item(hcbp_pkg::KIND_LOAD, 3, 32'hA5A5_5A5A, 40));
    send_item(make_item(hcbp_pkg::KIND_LOAD, 4, 32'h0000_0000, 63));
    send_item(make_item(hcbp_pkg::KIND_LOAD, 5, 32'h0000_00C3, 8));
    // Zero length, a code too short to finish a byte, then one that finishes it.
    send_item(make_item(hcbp_pkg::KIND_ENCODE, 0, 32'd0, 0));
    send_item(make_item(hcbp_pkg::KIND_ENCODE, 1, 32'd0, 0));
    send_item(make_item(hcbp_pkg::KIND_ENCODE, 2, 32'd0, 0));
    // Flush with nothing pending gives the empty marker.
    send_item(make_item(hcbp_pkg::KIND_FLUSH, 0, 32'd0, 0));
    send_item(make_item(hcbp_pkg::KIND_ENCODE, 255, 32'd0, 0));
    send_item(make_item(hcbp_pkg::KIND_ENCODE, 1, 32'd0, 0));
    send_item(make_item(hcbp_pkg::KIND_ENCODE, 3, 32'd0, 0));
    send_item(make_item(hcbp_pkg::KIND_FLUSH, 0, 32'd0, 0));
    // Seven pending bits plus a saturated 32-bit code.
    send_item(make_item(hcbp_pkg::KIND_ENCODE, 2, 32'd0, 0));
    send_item(make_item(hcbp_pkg::KIND_ENCODE, 4, 32'd0, 0));
    send_item(make_item(hcbp_pkg::KIND_FLUSH, 0, 32'd0, 0));
    send_item(make_item(KIND_IGNORED, $urandom_range(0, 255), $urandom, 63));
    // A symbol that was never loaded has length zero.
    send_item(make_item(hcbp_pkg::KIND_ENCODE, 200, 32'd0, 0));
    send_item(make_item(hcbp_pkg::KIND_ENCODE, 5, 32'hFFFF_FFFF, 63));
    send_item(make_item(hcbp_pkg::KIND_FLUSH, 255, 32'hFFFF_FFFF, 63));
  endtask

  // Fills the small symbol set with codes, then streams random items.
  task automatic test_random_stream(input int count);
    int i;
    for (i = 0; i < 16; i++) begin
      send_item(make_item(hcbp_pkg::KIND_LOAD, i, $urandom, $urandom_range(1, 20)));
    end
    for (i = 0; i < count; i++) send_item(random_item());
  endtask

  // Receiver stalls for a long stretch while long codes keep coming.
  task automatic test_output_stall();
    int i;
    for (i = 20; i < 24; i++) begin
      send_item(make_item(hcbp_pkg::KIND_LOAD, i, $urandom, $urandom_range(25, 32)));
    end
    no_idle = 1'b1;
    hold_request = HOLD_OFF_CYCLES;
    for (i = 0; i < 24; i++) begin
      send_item(make_item(hcbp_pkg::KIND_ENCODE, $urandom_range(20, 23), 32'd0, 0));
    end
    no_idle = 1'b0;
    send_item(make_item(hcbp_pkg::KIND_FLUSH, 0, 32'd0, 0));
  endtask

  // Sender pauses until every byte is out, then resumes.
  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 8; i++) send_item(random_item());
    wait_drain();
    for (i = 0; i < 8; i++) send_item(random_item());
  endtask

  // Both sides at full rate.
  task automatic test_full_rate();
    int i;
    no_idle = 1'b1;
    for (i = 0; i < 24; i++) send_item(random_item());
    send_item(make_item(hcbp_pkg::KIND_FLUSH, 0, 32'd0, 0));
    no_idle = 1'b0;
  endtask

  // Receiver: random stall before each beat, and a long hold-off on request.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        m_axis_tready = 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid && hold_request == 0) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compares each output beat with the oldest expected byte.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected beat", {15'd0, m_axis_tlast, m_axis_tdata}, 32'd0);
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata[7:0] !== want.data)
          report_mismatch("packed_byte", 32'(m_axis_tdata[7:0]), 32'(want.data));
        if (m_axis_tuser !== want.valid)
          report_mismatch("byte_valid", 32'(m_axis_tuser), 32'(want.valid));
        if (m_axis_tdata[10:8] !== want.pad)
          report_mismatch("pad_bits", 32'(m_axis_tdata[10:8]), 32'(want.pad));
        if (m_axis_tlast !== want.last)
          report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    int i;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    error_count = 0;
    cycle_count = 0;
    hold_request = 0;
    no_idle = 1'b0;
    held_bits = '0;
    held_count = 0;
    for (i = 0; i < hcbp_pkg::TABLE_DEPTH; i++) begin
      shadow_code[i] = '0;
      shadow_len[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_stream(120);
    test_output_stall();
    test_drain_pause();
    test_full_rate();

    // Let the last bytes come out, then allow for any stray beat.
    s_axis_tvalid = 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (pending_bytes.size() != 0)
      report_mismatch("bytes never seen", pending_bytes.size(), 32'd0);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* huffman_code_bit_packer_core.f */
hdl/hcbp_pkg.sv
hdl/hcbp_ram.sv
hdl/hcbp_pack.sv
hdl/hcbp_emit.sv
hdl/huffman_code_bit_packer_core.sv
test/huffman_code_bit_packer_core_tb.sv
